@@ rtl/core/sot_pkg.sv @@
// ============================================================================
// sot_pkg: stroke outline tessellator package
// Shared constants, command and status types and fixed point helpers.
// ============================================================================
`default_nettype none

package sot_pkg;

   // Number of vertices in one round cap disc.
   localparam int DISC_STEPS = 16;
   // Vertex index width: covers a disc and a quad.
   localparam int AW = $clog2(DISC_STEPS);
   // Disc phase advances by 65536/DISC_STEPS with a carried remainder.
   localparam int PH_STEP = 65536 / DISC_STEPS;
   localparam int PH_REM = 65536 % DISC_STEPS;
   localparam int PRW = $clog2(DISC_STEPS) + 1;
   // Width of the offset dividend and of the divider quotient.
   localparam int DIV_BITS = 46;

   // Quarter wave sine table, Q1.14.
   localparam logic [14:0] SIN_TAB [0:16] = '{
      15'd0, 15'd1606, 15'd3196, 15'd4756, 15'd6270, 15'd7723, 15'd9102,
      15'd10394, 15'd11585, 15'd12665, 15'd13623, 15'd14449, 15'd15137,
      15'd15679, 15'd16069, 15'd16305, 15'd16384
   };

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_SQ_DX,
      OP_SQ_DY,
      OP_CMP,
      OP_SQRT_START,
      OP_DIV_START,
      OP_QVERT,
      OP_DTRIG,
      OP_DXC,
      OP_DVERT,
      OP_AREA1,
      OP_AREA2,
      OP_CLOSE1,
      OP_CLOSE2,
      OP_READ
   } sot_op_type;

   typedef struct packed {
      sot_op_type      op;
      logic [AW-1:0]   idx;
      logic            quad;
      logic            disc_last;
      logic            run_final;
      logic            load_out;
      logic            commit;
   } sot_cmd_type;

   typedef struct packed {
      logic has_prev;
      logic b_last;
      logic seg_long;
      logic sq_busy;
      logic div_busy;
      logic out_free;
   } sot_stat_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DISPATCH,
      S_SQX,
      S_SQY,
      S_CMP,
      S_CHK,
      S_SQRT_GO,
      S_SQRT_WAIT,
      S_DIV_GO,
      S_DIV_WAIT,
      S_QVERT,
      S_DTRIG,
      S_DXC,
      S_DVERT,
      S_AREA1,
      S_AREA2,
      S_CLOSE1,
      S_CLOSE2,
      S_EMIT_RD,
      S_EMIT_LD,
      S_COMMIT
   } sot_state_type;

   // Saturate a wide signed value to the 24 bit coordinate range.
   function automatic logic signed [23:0] sot_sat24(input logic signed [47:0] v);
      if (v > 48'sd8388607) begin
         return 24'sd8388607;
      end
      if (v < -48'sd8388608) begin
         return -24'sd8388608;
      end
      return v[23:0];
   endfunction

   // Sine over the first quarter, input 0..16384, linear interpolation.
   function automatic logic [14:0] sot_qsin(input logic [14:0] u);
      logic [4:0]  k;
      logic [9:0]  f;
      logic [14:0] d;
      logic [24:0] p;
      k = {1'b0, u[13:10]};
      f = u[9:0];
      d = SIN_TAB[k + 5'd1] - SIN_TAB[k];
      p = 25'(d) * 25'(f) + 25'd512;
      if (u[14]) begin
         return 15'd16384;
      end
      return SIN_TAB[k] + p[24:10];
   endfunction

   // Full wave sine of a 16 bit phase, Q1.14 signed.
   function automatic logic signed [15:0] sot_sin16(input logic [15:0] ph);
      logic [14:0] u;
      logic [14:0] m;
      u = ph[14] ? (15'd16384 - {1'b0, ph[13:0]}) : {1'b0, ph[13:0]};
      m = sot_qsin(u);
      return ph[15] ? -$signed({1'b0, m}) : $signed({1'b0, m});
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/sot_if.sv @@
// ============================================================================
// sot_if: stroke outline tessellator channels
// Valid/ready channels for stroke points and emitted vertices.
// ============================================================================
`default_nettype none

interface sot_req_if;
   logic               valid;
   logic               ready;
   logic signed [23:0] x;
   logic signed [23:0] y;
   logic [15:0]        width;
   logic               last_point;

   modport source (output valid, x, y, width, last_point, input ready);
   modport sink (input valid, x, y, width, last_point, output ready);
endinterface

interface sot_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [23:0] vx;
   logic signed [23:0] vy;
   logic               polygon_end;
   logic               run_end;

   modport source (output valid, vx, vy, polygon_end, run_end, input ready);
   modport sink (input valid, vx, vy, polygon_end, run_end, output ready);
endinterface

`default_nettype wire

@@ rtl/core/sot_ctrl.sv @@
// ============================================================================
// sot_ctrl: stroke outline tessellator controller
// Sequences segment test, square root, divisions, polygon build and emission.
// ============================================================================
`default_nettype none

module sot_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire sot_pkg::sot_stat_type stat,
   output sot_pkg::sot_cmd_type       cmd
);
   import sot_pkg::*;

   sot_state_type state_ff, state_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic          quad_ff, quad_in;
   logic          dlast_ff, dlast_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
         quad_ff  <= 1'b0;
         dlast_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         quad_ff  <= quad_in;
         dlast_ff <= dlast_in;
      end
   end

   always_comb begin
      logic [AW-1:0] last_i;
      sot_state_type vstate;
      last_i = quad_ff ? AW'(3) : AW'(DISC_STEPS - 1);
      vstate = quad_ff ? S_QVERT : S_DTRIG;
      state_in = state_ff;
      idx_in = idx_ff;
      quad_in = quad_ff;
      dlast_in = dlast_ff;
      in_ready = 1'b0;
      cmd.op = OP_NONE;
      cmd.idx = idx_ff;
      cmd.quad = quad_ff;
      cmd.disc_last = dlast_ff;
      cmd.run_final = !quad_ff && (dlast_ff || !stat.b_last);
      cmd.load_out = 1'b0;
      cmd.commit = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.op = OP_CAPTURE;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            idx_in = '0;
            quad_in = 1'b0;
            if (stat.has_prev) begin
               state_in = S_SQX;
            end else if (stat.b_last) begin
               dlast_in = 1'b1;
               state_in = S_DTRIG;
            end else begin
               state_in = S_COMMIT;
            end
         end
         S_SQX: begin
            cmd.op = OP_SQ_DX;
            state_in = S_SQY;
         end
         S_SQY: begin
            cmd.op = OP_SQ_DY;
            state_in = S_CMP;
         end
         S_CMP: begin
            cmd.op = OP_CMP;
            state_in = S_CHK;
         end
         S_CHK: begin
            idx_in = '0;
            if (stat.seg_long) begin
               state_in = S_SQRT_GO;
            end else begin
               quad_in = 1'b0;
               dlast_in = 1'b0;
               state_in = S_DTRIG;
            end
         end
         S_SQRT_GO: begin
            cmd.op = OP_SQRT_START;
            state_in = S_SQRT_WAIT;
         end
         S_SQRT_WAIT: begin
            if (!stat.sq_busy) begin
               idx_in = '0;
               state_in = S_DIV_GO;
            end
         end
         S_DIV_GO: begin
            cmd.op = OP_DIV_START;
            state_in = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (!stat.div_busy) begin
               if (idx_ff == AW'(3)) begin
                  idx_in = '0;
                  quad_in = 1'b1;
                  state_in = S_QVERT;
               end else begin
                  idx_in = idx_ff + AW'(1);
                  state_in = S_DIV_GO;
               end
            end
         end
         S_QVERT, S_DVERT: begin
            cmd.op = (state_ff == S_QVERT) ? OP_QVERT : OP_DVERT;
            if (idx_ff == '0) begin
               idx_in = idx_ff + AW'(1);
               state_in = vstate;
            end else begin
               state_in = S_AREA1;
            end
         end
         S_DTRIG: begin
            cmd.op = OP_DTRIG;
            state_in = S_DXC;
         end
         S_DXC: begin
            cmd.op = OP_DXC;
            state_in = S_DVERT;
         end
         S_AREA1: begin
            cmd.op = OP_AREA1;
            state_in = S_AREA2;
         end
         S_AREA2: begin
            cmd.op = OP_AREA2;
            if (idx_ff == last_i) begin
               state_in = S_CLOSE1;
            end else begin
               idx_in = idx_ff + AW'(1);
               state_in = vstate;
            end
         end
         S_CLOSE1: begin
            cmd.op = OP_CLOSE1;
            state_in = S_CLOSE2;
         end
         S_CLOSE2: begin
            cmd.op = OP_CLOSE2;
            idx_in = '0;
            state_in = S_EMIT_RD;
         end
         S_EMIT_RD: begin
            cmd.op = OP_READ;
            state_in = S_EMIT_LD;
         end
         S_EMIT_LD: begin
            if (stat.out_free) begin
               cmd.load_out = 1'b1;
               if (idx_ff == last_i) begin
                  idx_in = '0;
                  if (quad_ff) begin
                     quad_in = 1'b0;
                     dlast_in = 1'b0;
                     state_in = S_DTRIG;
                  end else if (!dlast_ff && stat.b_last) begin
                     dlast_in = 1'b1;
                     state_in = S_DTRIG;
                  end else begin
                     state_in = S_COMMIT;
                  end
               end else begin
                  idx_in = idx_ff + AW'(1);
                  state_in = S_EMIT_RD;
               end
            end
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/core/sot_dp.sv @@
// ============================================================================
// sot_dp: stroke outline tessellator datapath
// Point state, square root and divider units, vertex build, area, output.
// ============================================================================
`default_nettype none

module sot_dp (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire sot_pkg::sot_cmd_type  cmd,
   output sot_pkg::sot_stat_type      stat,
   input  wire logic                  cfg_we,
   input  wire logic [15:0]           cfg_data,
   input  wire logic signed [23:0]    in_x,
   input  wire logic signed [23:0]    in_y,
   input  wire logic [15:0]           in_width,
   input  wire logic                  in_last,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output logic signed [23:0]         out_vx,
   output logic signed [23:0]         out_vy,
   output logic                       out_polygon_end,
   output logic                       out_run_end
);
   import sot_pkg::*;

   logic [15:0]        msl_ff;
   logic signed [23:0] prev_x_ff, prev_y_ff;
   logic [15:0]        prev_r_ff;
   logic               have_prev_ff;
   logic signed [23:0] b_x_ff, b_y_ff;
   logic [15:0]        b_r_ff;
   logic               b_last_ff;

   logic signed [24:0] dx, dy;
   logic signed [24:0] sq_op;
   logic signed [49:0] sq_prod;
   logic [49:0]        l2_ff;
   logic               seg_long_ff;

   logic [63:0]        sq_v_ff, sq_res_ff, sq_bit_ff;
   logic [63:0]        sq_trial;
   logic [30:0]        len14;

   logic signed [24:0] d_sel;
   logic [23:0]        d_mag;
   logic [15:0]        r_sel;
   logic [39:0]        m_prod;
   logic [DIV_BITS-1:0] dv_n_ff;
   logic [30:0]        dv_rem_ff;
   logic [5:0]         dv_cnt_ff;
   logic               dv_neg_ff;
   logic [1:0]         dv_k_ff;
   logic [31:0]        dv_trial;
   logic               dv_qbit;
   logic [DIV_BITS-1:0] dv_q;
   logic signed [41:0] dv_res;
   logic signed [41:0] oxa_ff, oya_ff, oxb_ff, oyb_ff;

   logic signed [23:0] qb_x, qb_y;
   logic signed [41:0] qo_x, qo_y;
   logic signed [23:0] qv_x, qv_y;

   logic signed [23:0] c_x, c_y;
   logic [15:0]        c_r;
   logic [15:0]        ph_ff, ph_cur;
   logic [PRW-1:0]     phr_ff, phr_cur;
   logic [PRW:0]       phr_sum;
   logic signed [15:0] cos_ff, sin_ff;
   logic signed [32:0] t_prod;
   logic signed [23:0] dv_x_ff, dv_y;

   logic signed [23:0] nv_x, nv_y;
   logic signed [23:0] cur_x_ff, cur_y_ff, prv_x_ff, prv_y_ff, fst_x_ff, fst_y_ff;
   logic signed [47:0] aprod_ff;
   logic signed [55:0] area_ff;
   logic signed [23:0] a_x, a_y, bb_x, bb_y;

   logic [47:0]        vmem_ff [DISC_STEPS];
   logic [47:0]        rd_ff;
   logic [AW-1:0]      last_i, rd_addr;

   logic               rsp_valid_ff;
   logic signed [23:0] rsp_vx_ff, rsp_vy_ff;
   logic               rsp_pe_ff, rsp_re_ff;

   // ---------------- point state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         msl_ff <= '0;
         prev_x_ff <= '0;
         prev_y_ff <= '0;
         prev_r_ff <= '0;
         have_prev_ff <= 1'b0;
      end else begin
         if (cfg_we) begin
            msl_ff <= cfg_data;
         end
         if (cmd.commit) begin
            if (b_last_ff) begin
               have_prev_ff <= 1'b0;
            end else begin
               prev_x_ff <= b_x_ff;
               prev_y_ff <= b_y_ff;
               prev_r_ff <= b_r_ff;
               have_prev_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_CAPTURE) begin
         b_x_ff <= in_x;
         b_y_ff <= in_y;
         b_r_ff <= in_width;
         b_last_ff <= in_last;
      end
   end

   // ---------------- squared length and threshold test
   assign dx = 25'(b_x_ff) - 25'(prev_x_ff);
   assign dy = 25'(b_y_ff) - 25'(prev_y_ff);
   assign sq_op = (cmd.op == OP_SQ_DX) ? dx : dy;
   assign sq_prod = sq_op * sq_op;

   always_ff @(posedge clock) begin
      if (cmd.op == OP_SQ_DX) begin
         l2_ff <= $unsigned(sq_prod);
      end else if (cmd.op == OP_SQ_DY) begin
         l2_ff <= l2_ff + $unsigned(sq_prod);
      end
      if (cmd.op == OP_CMP) begin
         seg_long_ff <= l2_ff > 50'(32'(msl_ff) * 32'(msl_ff));
      end
   end

   // ---------------- square root, one result bit per cycle
   assign sq_trial = sq_res_ff + sq_bit_ff;
   assign len14 = sq_res_ff[30:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_bit_ff <= '0;
      end else if (cmd.op == OP_SQRT_START) begin
         sq_bit_ff <= 64'd1 << 62;
      end else if (sq_bit_ff != '0) begin
         sq_bit_ff <= sq_bit_ff >> 2;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_SQRT_START) begin
         sq_v_ff <= {2'b00, l2_ff, 12'd0};
         sq_res_ff <= '0;
      end else if (sq_bit_ff != '0) begin
         if (sq_v_ff >= sq_trial) begin
            sq_v_ff <= sq_v_ff - sq_trial;
            sq_res_ff <= (sq_res_ff >> 1) + sq_bit_ff;
         end else begin
            sq_res_ff <= sq_res_ff >> 1;
         end
      end
   end

   // ---------------- offset divider, restoring, one quotient bit per cycle
   assign d_sel = cmd.idx[0] ? dx : -dy;
   assign d_mag = d_sel[24] ? 24'(-d_sel) : d_sel[23:0];
   assign r_sel = cmd.idx[1] ? b_r_ff : prev_r_ff;
   assign m_prod = 40'(d_mag) * 40'(r_sel);

   assign dv_trial = {dv_rem_ff, dv_n_ff[DIV_BITS-1]};
   assign dv_qbit = dv_trial >= {1'b0, len14};
   assign dv_q = {dv_n_ff[DIV_BITS-2:0], dv_qbit};
   assign dv_res = dv_neg_ff ? -$signed({1'b0, dv_q[40:0]}) : $signed({1'b0, dv_q[40:0]});

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_cnt_ff <= '0;
      end else if (cmd.op == OP_DIV_START) begin
         dv_cnt_ff <= 6'(DIV_BITS);
      end else if (dv_cnt_ff != '0) begin
         dv_cnt_ff <= dv_cnt_ff - 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_DIV_START) begin
         dv_n_ff <= DIV_BITS'({m_prod, 5'd0}) + DIV_BITS'(len14[30:1]);
         dv_rem_ff <= '0;
         dv_neg_ff <= d_sel[24];
         dv_k_ff <= cmd.idx[1:0];
      end else if (dv_cnt_ff != '0) begin
         dv_n_ff <= dv_q;
         dv_rem_ff <= dv_qbit ? 31'(dv_trial - {1'b0, len14}) : dv_trial[30:0];
         if (dv_cnt_ff == 6'd1) begin
            unique case (dv_k_ff)
               2'd0: oxa_ff <= dv_res;
               2'd1: oya_ff <= dv_res;
               2'd2: oxb_ff <= dv_res;
               default: oyb_ff <= dv_res;
            endcase
         end
      end
   end

   // ---------------- quad corners
   always_comb begin
      if (cmd.idx[1] == cmd.idx[0]) begin
         qb_x = prev_x_ff;
         qb_y = prev_y_ff;
         qo_x = oxa_ff;
         qo_y = oya_ff;
      end else begin
         qb_x = b_x_ff;
         qb_y = b_y_ff;
         qo_x = oxb_ff;
         qo_y = oyb_ff;
      end
      if (cmd.idx[1]) begin
         qv_x = sot_sat24(48'(qb_x) - 48'(qo_x));
         qv_y = sot_sat24(48'(qb_y) - 48'(qo_y));
      end else begin
         qv_x = sot_sat24(48'(qb_x) + 48'(qo_x));
         qv_y = sot_sat24(48'(qb_y) + 48'(qo_y));
      end
   end

   // ---------------- disc vertices
   assign c_x = cmd.disc_last ? b_x_ff : prev_x_ff;
   assign c_y = cmd.disc_last ? b_y_ff : prev_y_ff;
   assign c_r = cmd.disc_last ? b_r_ff : prev_r_ff;
   assign ph_cur = (cmd.idx == '0) ? '0 : ph_ff;
   assign phr_cur = (cmd.idx == '0) ? '0 : phr_ff;
   assign phr_sum = (PRW + 1)'(phr_cur) + (PRW + 1)'(PH_REM);
   assign t_prod = $signed({1'b0, c_r}) * ((cmd.op == OP_DXC) ? cos_ff : sin_ff);
   assign dv_y = sot_sat24(48'(c_y) + 48'($signed(t_prod + 33'sd16384) >>> 15));

   always_ff @(posedge clock) begin
      if (cmd.op == OP_DTRIG) begin
         cos_ff <= sot_sin16(ph_cur + 16'd16384);
         sin_ff <= sot_sin16(ph_cur);
      end
      if (cmd.op == OP_DXC) begin
         dv_x_ff <= sot_sat24(48'(c_x) + 48'($signed(t_prod + 33'sd16384) >>> 15));
      end
      if (cmd.op == OP_DVERT) begin
         if (phr_sum >= (PRW + 1)'(DISC_STEPS)) begin
            phr_ff <= PRW'(phr_sum - (PRW + 1)'(DISC_STEPS));
            ph_ff <= ph_cur + 16'(PH_STEP) + 16'd1;
         end else begin
            phr_ff <= PRW'(phr_sum);
            ph_ff <= ph_cur + 16'(PH_STEP);
         end
      end
   end

   // ---------------- vertex store and signed area
   assign nv_x = (cmd.op == OP_QVERT) ? qv_x : dv_x_ff;
   assign nv_y = (cmd.op == OP_QVERT) ? qv_y : dv_y;
   assign a_x = (cmd.op == OP_CLOSE1 || cmd.op == OP_CLOSE2) ? cur_x_ff : prv_x_ff;
   assign a_y = (cmd.op == OP_CLOSE1 || cmd.op == OP_CLOSE2) ? cur_y_ff : prv_y_ff;
   assign bb_x = (cmd.op == OP_CLOSE1 || cmd.op == OP_CLOSE2) ? fst_x_ff : cur_x_ff;
   assign bb_y = (cmd.op == OP_CLOSE1 || cmd.op == OP_CLOSE2) ? fst_y_ff : cur_y_ff;
   assign last_i = cmd.quad ? AW'(3) : AW'(DISC_STEPS - 1);
   assign rd_addr = area_ff[55] ? (last_i - cmd.idx) : cmd.idx;

   always_ff @(posedge clock) begin
      if (cmd.op == OP_QVERT || cmd.op == OP_DVERT) begin
         vmem_ff[cmd.idx] <= {nv_x, nv_y};
         prv_x_ff <= cur_x_ff;
         prv_y_ff <= cur_y_ff;
         cur_x_ff <= nv_x;
         cur_y_ff <= nv_y;
         if (cmd.idx == '0) begin
            fst_x_ff <= nv_x;
            fst_y_ff <= nv_y;
            area_ff <= '0;
         end
      end
      if (cmd.op == OP_AREA1 || cmd.op == OP_CLOSE1) begin
         aprod_ff <= a_x * bb_y;
      end
      if (cmd.op == OP_AREA2 || cmd.op == OP_CLOSE2) begin
         area_ff <= area_ff + 56'(aprod_ff) - 56'(bb_x * a_y);
      end
      if (cmd.op == OP_READ) begin
         rd_ff <= vmem_ff[rd_addr];
      end
   end

   // ---------------- output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (out_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_vx_ff <= rd_ff[47:24];
         rsp_vy_ff <= rd_ff[23:0];
         rsp_pe_ff <= cmd.idx == last_i;
         rsp_re_ff <= (cmd.idx == last_i) && cmd.run_final;
      end
   end

   assign out_valid = rsp_valid_ff;
   assign out_vx = rsp_vx_ff;
   assign out_vy = rsp_vy_ff;
   assign out_polygon_end = rsp_pe_ff;
   assign out_run_end = rsp_re_ff;

   assign stat.has_prev = have_prev_ff;
   assign stat.b_last = b_last_ff;
   assign stat.seg_long = seg_long_ff;
   assign stat.sq_busy = sq_bit_ff != '0;
   assign stat.div_busy = dv_cnt_ff != '0;
   assign stat.out_free = !rsp_valid_ff || out_ready;

   // ---------------- assertions
   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !((sq_bit_ff != '0) && (dv_cnt_ff != '0)))
      else $error("square root and divider busy together");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_valid_ff)
      else $error("vertex load did not raise valid");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || out_ready))
      else $error("pending vertex overwritten");

   a_quad_index: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_QVERT) |-> (cmd.idx <= AW'(3)))
      else $error("quad corner index out of range");

endmodule

`default_nettype wire

@@ rtl/core/stroke_outline_tessellator_unit.sv @@
// ============================================================================
// stroke_outline_tessellator_unit: variable width stroke outline tessellator
// Turns stroke points into quad and round cap disc polygons, vertex by vertex.
// ============================================================================
// Usage: stroke points enter on req_ch (x, y, width, last_point) and vertices
// leave on rsp_ch (vx, vy, polygon_end, run_end), each a valid/ready
// transaction. csr_we with csr_wdata writes the minimum segment length; write
// it only while the block is idle.
// One point is processed at a time; req_ch.ready is high only between points.
// A first point that is not last only updates the stored point.
// A disc builds each vertex and its area term in turn (trig, x, vertex and
// area steps), then closes the area and emits each vertex with a read and
// a load step. A segment longer than the threshold adds a quad; the bit
// serial square root and four offset divisions dominate its cost. After the
// last vertex of a polygon is stored, the area is closed and the first
// vertex is read and loaded into the output register, which raises valid.
// After reset the stored point is cleared, the threshold is zero and no
// vertex is pending. When the receiver stalls, the output register holds
// the vertex and the sequencer waits; nothing is lost or dropped.
// ============================================================================
`default_nettype none

module stroke_outline_tessellator_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   sot_req_if.sink          req_ch,
   sot_rsp_if.source        rsp_ch,
   input  wire logic        csr_we,
   input  wire logic [15:0] csr_wdata
);
   import sot_pkg::*;

   sot_cmd_type  cmd;
   sot_stat_type stat;
   logic         in_ready;

   // The controller owns the accept decision; the datapath captures the
   // point on the capture command issued in the same cycle.
   sot_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_ch.valid),
      .in_ready (in_ready),
      .stat     (stat),
      .cmd      (cmd)
   );

   sot_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .cfg_we          (csr_we),
      .cfg_data        (csr_wdata),
      .in_x            (req_ch.x),
      .in_y            (req_ch.y),
      .in_width        (req_ch.width),
      .in_last         (req_ch.last_point),
      .out_valid       (rsp_ch.valid),
      .out_ready       (rsp_ch.ready),
      .out_vx          (rsp_ch.vx),
      .out_vy          (rsp_ch.vy),
      .out_polygon_end (rsp_ch.polygon_end),
      .out_run_end     (rsp_ch.run_end)
   );

   assign req_ch.ready = in_ready;

endmodule

`default_nettype wire

@@ bench/tb_sot_channels.sv @@
// ============================================================================
// tb_sot_channels: bench-side notes for the tessellator channels
// The channel interfaces come from the RTL; this file holds the bench package.
// ============================================================================
`default_nettype none

package tb_sot_pkg;

   // One emitted vertex as the bench predicts it.
   typedef struct packed {
      logic signed [23:0] vx;
      logic signed [23:0] vy;
      logic               polygon_end;
      logic               run_end;
   } vertex_type;

endpackage

`default_nettype wire

@@ bench/tb_top.sv @@
// ============================================================================
// tb_top: stroke outline tessellator testbench
// Drives stroke points with random gaps, predicts every quad and disc vertex
// in a scoreboard class, and compares each emitted vertex field by field.
// ============================================================================
`default_nettype none

module tb_top;
   import sot_pkg::*;
   import tb_sot_pkg::*;

   // Quarter-wave sine table in Q1.14, used by the outline predictor.
   localparam int SINE_QTR [0:16] = '{0, 1606, 3196, 4756, 6270, 7723, 9102, 10394,
      11585, 12665, 13623, 14449, 15137, 15679, 16069, 16305, 16384};

   // The outline predictor keeps its own copy of the stroke state and the
   // threshold, and queues the vertices that each point should produce.
   class outline_scoreboard;
      vertex_type  pending[$];
      logic [15:0] min_len;
      longint      last_x, last_y;
      int          last_r;
      bit          have_last;
      int          errors, vertices, points, quads;

      function void clear();
         pending.delete();
         min_len = 0; last_x = 0; last_y = 0; last_r = 0; have_last = 0;
      endfunction

      function longint clamp24(longint v);
         if (v > 8388607) return 8388607;
         if (v < -8388608) return -8388608;
         return v;
      endfunction

      function longint qsin(int u);
         int k, f;
         if (u >= 16384) return 16384;
         k = u >> 10;
         f = u & 1023;
         return SINE_QTR[k] + (((SINE_QTR[k + 1] - SINE_QTR[k]) * f + 512) >> 10);
      endfunction

      function longint sine(int ph);
         int     q, p;
         longint m;
         q = (ph >> 14) & 3;
         p = ph & 16'h3FFF;
         m = (q & 1) ? qsin(16384 - p) : qsin(p);
         return (q & 2) ? -m : m;
      endfunction

      // Floor of (v + half) / 2^15; arithmetic shift is already a floor.
      function longint round15(longint v);
         return (v + 16384) >>> 15;
      endfunction

      function longint root(longint v);
         longint r, b;
         r = 0;
         b = 64'sd1 <<< 62;
         while (b > v) b = b >>> 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >>> 1) + b;
            end else begin
               r = r >>> 1;
            end
            b = b >>> 2;
         end
         return r;
      endfunction

      // Offset d*r/(2*len), rounded half away from zero.
      function longint offset(longint d, int r, longint len14);
         longint mag, q;
         mag = (d < 0 ? -d : d) * r * 32;
         q = (mag + len14 / 2) / len14;
         return d < 0 ? -q : q;
      endfunction

      // A polygon whose signed area is negative is queued reversed.
      function void queue_polygon(longint px[], longint py[]);
         longint     area;
         int         n, j, s;
         vertex_type v;
         n = px.size();
         area = 0;
         for (int i = 0; i < n; i++) begin
            j = (i + 1 == n) ? 0 : i + 1;
            area += px[i] * py[j] - px[j] * py[i];
         end
         for (int i = 0; i < n; i++) begin
            s = (area < 0) ? n - 1 - i : i;
            v.vx = px[s][23:0];
            v.vy = py[s][23:0];
            v.polygon_end = (i == n - 1);
            v.run_end = 0;
            pending.push_back(v);
         end
      endfunction

      function void queue_disc(longint cx, longint cy, int r);
         longint px[], py[];
         int     ph;
         px = new[DISC_STEPS];
         py = new[DISC_STEPS];
         for (int i = 0; i < DISC_STEPS; i++) begin
            ph = (i * 65536 / DISC_STEPS) & 16'hFFFF;
            px[i] = clamp24(cx + round15(r * sine((ph + 16384) & 16'hFFFF)));
            py[i] = clamp24(cy + round15(r * sine(ph)));
         end
         queue_polygon(px, py);
      endfunction

      // Notes one accepted point and queues the vertices it causes.
      function void note_point(logic signed [23:0] x, logic signed [23:0] y,
                               logic [15:0] w, logic fin);
         longint dx, dy, l2, len14, oxa, oya, oxb, oyb;
         longint qx[], qy[];
         int     before_n;
         before_n = pending.size();
         points++;
         if (have_last) begin
            dx = x - last_x;
            dy = y - last_y;
            l2 = dx * dx + dy * dy;
            if (l2 > longint'(min_len) * min_len) begin
               quads++;
               len14 = root(l2 <<< 12);
               oxa = offset(-dy, last_r, len14);
               oya = offset(dx, last_r, len14);
               oxb = offset(-dy, w, len14);
               oyb = offset(dx, w, len14);
               qx = new[4];
               qy = new[4];
               qx[0] = clamp24(last_x + oxa); qy[0] = clamp24(last_y + oya);
               qx[1] = clamp24(x + oxb);      qy[1] = clamp24(y + oyb);
               qx[2] = clamp24(x - oxb);      qy[2] = clamp24(y - oyb);
               qx[3] = clamp24(last_x - oxa); qy[3] = clamp24(last_y - oya);
               queue_polygon(qx, qy);
            end
            queue_disc(last_x, last_y, last_r);
         end
         if (fin) begin
            queue_disc(x, y, w);
            have_last = 0;
         end else begin
            last_x = x; last_y = y; last_r = w; have_last = 1;
         end
         if (pending.size() > before_n) pending[pending.size() - 1].run_end = 1;
      endfunction

      // Compares one emitted vertex with the oldest expected one.
      function void check_vertex(vertex_type got);
         vertex_type exp_v;
         vertices++;
         if (pending.size() == 0) begin
            $error("unexpected vertex vx=%0d vy=%0d", got.vx, got.vy);
            errors++;
            return;
         end
         exp_v = pending.pop_front();
         if (got.vx !== exp_v.vx) begin
            $error("vx expected %0d actual %0d", exp_v.vx, got.vx); errors++;
         end
         if (got.vy !== exp_v.vy) begin
            $error("vy expected %0d actual %0d", exp_v.vy, got.vy); errors++;
         end
         if (got.polygon_end !== exp_v.polygon_end) begin
            $error("polygon_end expected %0b actual %0b", exp_v.polygon_end,
                   got.polygon_end);
            errors++;
         end
         if (got.run_end !== exp_v.run_end) begin
            $error("run_end expected %0b actual %0b", exp_v.run_end, got.run_end);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_we = 0;
   logic [15:0] csr_wdata = 0;
   bit          long_stall = 0;
   bit          stim_done = 0;

   sot_req_if req_ch ();
   sot_rsp_if rsp_ch ();

   outline_scoreboard board = new();

   stroke_outline_tessellator_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .rsp_ch   (rsp_ch),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   initial begin
      req_ch.valid = 0;
      req_ch.x = 0;
      req_ch.y = 0;
      req_ch.width = 0;
      req_ch.last_point = 0;
      rsp_ch.ready = 0;
   end

   // Every point transaction is noted by the predictor at the edge that
   // accepts it, and every vertex transaction is checked at its edge.
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         board.note_point(req_ch.x, req_ch.y, req_ch.width, req_ch.last_point);
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         board.check_vertex('{rsp_ch.vx, rsp_ch.vy, rsp_ch.polygon_end, rsp_ch.run_end});
      end
   end

   // The receiver takes each vertex at once or after a random delay; during the
   // long hold-off it holds ready low so the block fills and stalls.
   initial begin : receiver
      int gap;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (long_stall) begin
            rsp_ch.ready <= 0;
            for (int i = 0; i < 600; i++) @(posedge clock);
            long_stall = 0;
         end
         gap = $urandom_range(0, 3);
         if ($urandom_range(0, 3) == 0) gap = 0;
         rsp_ch.ready <= (gap == 0);
         if (gap != 0) begin
            for (int i = 1; i < gap; i++) @(posedge clock);
            @(posedge clock);
            rsp_ch.ready <= 1;
         end
         while (!(rsp_ch.valid && rsp_ch.ready)) @(posedge clock);
         rsp_ch.ready <= 0;
      end
   end

   // Offers one point and holds it until the transaction completes. When the
   // next point draws no idle cycles, valid simply stays high into it.
   task automatic send_point(logic signed [23:0] x, logic signed [23:0] y,
                             logic [15:0] w, logic fin);
      int gap;
      gap = $urandom_range(0, 3);
      if ($urandom_range(0, 2) == 0) gap = 0;
      if (gap != 0) begin
         req_ch.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1;
      req_ch.x <= x;
      req_ch.y <= y;
      req_ch.width <= w;
      req_ch.last_point <= fin;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // Waits until every expected vertex has left, then lets any trailing
   // point update settle before the threshold is rewritten.
   task automatic drain_and_write(logic [15:0] value);
      int guard;
      guard = 0;
      req_ch.valid <= 0;
      @(posedge clock);
      while (board.pending.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (20) @(posedge clock);
      csr_we <= 1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 0;
      board.min_len = value;
   endtask

   function automatic logic signed [23:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return 24'(24'sh7FFFFF - $urandom_range(0, 4000));
         1: return 24'(-24'sh800000 + $urandom_range(0, 4000));
         2: return 24'($urandom);
         default: return 24'($signed($urandom_range(0, 40000)) - 20000);
      endcase
   endfunction

   function automatic logic [15:0] rand_width();
      case ($urandom_range(0, 4))
         0: return 16'(16'hFFFF - $urandom_range(0, 255));
         1: return 0;
         2: return 16'($urandom);
         default: return 16'($urandom_range(0, 6000));
      endcase
   endfunction

   // Stimulus: a directed stroke set over the extremes, then random strokes
   // of a few points each with the threshold changed between phases.
   initial begin : stimulus
      logic [15:0] thresholds [0:4];
      int          len;
      logic signed [23:0] bx, by;
      thresholds = '{16'd0, 16'hFFFF, 16'd256, 16'd4000, 16'd0};
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Single-point stroke, coincident points, zero radius, and a stroke
      // that runs off both coordinate extremes so vertices saturate.
      send_point(24'sd0, 24'sd0, 16'd512, 1);
      send_point(24'sd100, 24'sd100, 16'd0, 0);
      send_point(24'sd100, 24'sd100, 16'd0, 0);
      send_point(24'sd5000, -24'sd3000, 16'hFFFF, 0);
      send_point(24'sh7FFFFF, 24'sh7FFFFF, 16'hFFFF, 0);
      send_point(-24'sh800000, -24'sh800000, 16'hFFFF, 0);
      send_point(-24'sh800000, 24'sh7FFFFF, 16'd1, 0);
      send_point(24'sh7FFFFF, -24'sh800000, 16'h8000, 1);
      send_point(24'sh555555, -24'sh2AAAAB, 16'h5555, 0);
      send_point(-24'sh555556, 24'sh2AAAAA, 16'hAAAA, 1);
      drain_and_write(16'hFFFF);
      send_point(24'sd0, 24'sd0, 16'd300, 0);
      send_point(24'sd65535, 24'sd0, 16'd300, 0);
      send_point(24'sd0, 24'sd0, 16'd300, 1);

      // Random phases; the long receiver hold-off lands in the first one.
      foreach (thresholds[p]) begin
         drain_and_write(thresholds[p]);
         if (p == 0) long_stall = 1;
         for (int n = 0; n < 95;) begin
            len = $urandom_range(1, 6);
            bx = rand_coord();
            by = rand_coord();
            for (int k = 0; k < len; k++) begin
               if ($urandom_range(0, 1)) begin
                  bx = 24'(bx + $signed($urandom_range(0, 8000)) - 4000);
                  by = 24'(by + $signed($urandom_range(0, 8000)) - 4000);
               end else begin
                  bx = rand_coord();
                  by = rand_coord();
               end
               send_point(bx, by, rand_width(), k == len - 1);
               n++;
            end
         end
      end
      req_ch.valid <= 0;
      @(posedge clock);
      stim_done = 1;
   end

   // Ends the run once stimulus is done and nothing is expected any more.
   initial begin : finisher
      wait (stim_done);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      $display("Covered %0d points, %0d quads and %0d checked vertices.",
               board.points, board.quads, board.vertices);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin : watchdog
      #20000000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

`default_nettype wire

@@ files.f @@
rtl/core/sot_pkg.sv
rtl/core/sot_if.sv
rtl/core/sot_ctrl.sv
rtl/core/sot_dp.sv
rtl/core/stroke_outline_tessellator_unit.sv
bench/tb_sot_channels.sv
bench/tb_top.sv
